/* rtl/core/tea_pkg.sv */
// ----------------------------------------------------------------------------
// tea_pkg
// shared types, sizes and the edge hash for the edge adjacency builder
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int    VERTEX_BITS   = 16;
    localparam int    MAX_TRIANGLES = 65536;
    localparam int    EDGE_SLOTS    = 8192;
    localparam longint MAX_VERTICES = 65536;

    localparam int ADDR_BITS = $clog2(EDGE_SLOTS);
    localparam int TRI_BITS  = $clog2(MAX_TRIANGLES) + 1;
    localparam int SLOT_BITS = 18;

    localparam logic [ADDR_BITS-1:0] HASH_LO = ADDR_BITS'(64'd2654435761 % EDGE_SLOTS);
    localparam logic [ADDR_BITS-1:0] HASH_HI = ADDR_BITS'(64'd40503 % EDGE_SLOTS);

    localparam logic KIND_VMAP = 1'b0;
    localparam logic KIND_ADJ  = 1'b1;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] v0;
        logic [VERTEX_BITS-1:0] v1;
        logic [VERTEX_BITS-1:0] v2;
        logic                   first;
    } t_tri_item;

    typedef struct packed {
        logic                   valid;
        logic [VERTEX_BITS-1:0] lo;
        logic [VERTEX_BITS-1:0] hi;
        logic [SLOT_BITS-1:0]   base;
        logic [1:0]             opp;
    } t_edge;

    typedef struct packed {
        logic                 kind;
        logic [SLOT_BITS-1:0] slot;
        logic [SLOT_BITS-1:0] value;
        logic                 ovf;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic init_busy;
    } t_eng_status;

    function automatic logic [ADDR_BITS-1:0] edge_hash(
        input logic [VERTEX_BITS-1:0] lo,
        input logic [VERTEX_BITS-1:0] hi
    );
        logic [2*ADDR_BITS-1:0] pl;
        logic [2*ADDR_BITS-1:0] ph;
        pl = lo[ADDR_BITS-1:0] * HASH_LO;
        ph = hi[ADDR_BITS-1:0] * HASH_HI;
        return pl[ADDR_BITS-1:0] ^ ph[ADDR_BITS-1:0];
    endfunction

endpackage

/* rtl/core/tea_queue.sv */
// ----------------------------------------------------------------------------
// tea_queue
// two-entry triangle queue between front and engine
// ----------------------------------------------------------------------------
module tea_queue
    import tea_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_tri_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_tri_item o_item
);

    t_tri_item  r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* rtl/core/tea_front.sv */
// ----------------------------------------------------------------------------
// tea_front
// input acceptance, enable register and splitting of the input word into vertex indices
// ----------------------------------------------------------------------------
module tea_front
    import tea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [47:0] i_data,
    input  logic        i_first,
    input  t_eng_status i_status,
    input  logic        i_q_full,
    output logic        o_push,
    output t_tri_item   o_item
);

    logic r_gen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= 1'b1;
        end else if (i_cfg_we) begin
            r_gen <= i_cfg_wdata;
        end
    end

    assign o_ready      = !i_q_full && !i_status.init_busy;
    // disabled generation swallows the transaction
    assign o_push       = i_valid && o_ready && r_gen;
    assign o_item.v0    = i_data[VERTEX_BITS-1:0];
    assign o_item.v1    = i_data[16 +: VERTEX_BITS];
    assign o_item.v2    = i_data[32 +: VERTEX_BITS];
    assign o_item.first = i_first;

endmodule

/* rtl/core/tea_engine.sv */
// ----------------------------------------------------------------------------
// tea_engine
// edge table, probe sequencer and result staging
// ----------------------------------------------------------------------------
module tea_engine
    import tea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_tri_item   i_item,
    output logic        o_pop,
    output t_eng_status o_status,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_VMAP  = 4'd3;
    localparam logic [3:0] S_PSET  = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PCMP  = 4'd6;
    localparam logic [3:0] S_LNK0  = 4'd7;
    localparam logic [3:0] S_LNK1  = 4'd8;
    localparam logic [3:0] S_FLAG  = 4'd9;
    localparam logic [3:0] S_END   = 4'd10;

    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(EDGE_SLOTS - 1);

    t_edge r_mem [EDGE_SLOTS];
    t_edge r_rd;

    logic [3:0]             r_state;
    logic [ADDR_BITS-1:0]   r_addr;
    logic [ADDR_BITS-1:0]   r_k;
    logic [1:0]             r_c;
    logic [1:0]             r_e;
    t_tri_item              r_item;
    logic                   r_have;
    logic [TRI_BITS-1:0]    r_tri;
    logic [SLOT_BITS-1:0]   r_base;
    logic [VERTEX_BITS-1:0] r_lo;
    logic [VERTEX_BITS-1:0] r_hi;
    logic                   r_ovf;
    logic                   r_numbered;
    t_result                r_pend;
    logic                   r_pend_v;
    t_result                r_out;
    logic                   r_out_v;

    logic                   out_free;
    logic                   can_push;
    logic                   emit_go;
    logic                   fin_go;
    logic                   out_load;
    t_result                emit_res;
    t_result                pend_last;
    logic [VERTEX_BITS-1:0] corner_v;
    logic [VERTEX_BITS-1:0] ea;
    logic [VERTEX_BITS-1:0] eb;
    logic [1:0]             eopp;
    logic                   corner_ok;
    logic                   hit;
    logic                   mem_we;
    t_edge                  mem_wdata;

    assign out_free = !r_out_v || i_ready;
    assign can_push = !r_pend_v || out_free;
    assign out_load = r_pend_v && (emit_go || fin_go);
    assign o_valid  = r_out_v;
    assign o_result = r_out;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_status.init_busy = (r_state == S_CLR) && !r_have;

    always_comb begin
        pend_last      = r_pend;
        pend_last.last = 1'b1;
    end

    always_comb begin
        case (r_c)
            2'd0:    corner_v = r_item.v0;
            2'd1:    corner_v = r_item.v1;
            default: corner_v = r_item.v2;
        endcase
        case (r_e)
            2'd0: begin
                ea = r_item.v0; eb = r_item.v1; eopp = 2'd2;
            end
            2'd1: begin
                ea = r_item.v1; eb = r_item.v2; eopp = 2'd0;
            end
            default: begin
                ea = r_item.v2; eb = r_item.v0; eopp = 2'd1;
            end
        endcase
    end

    assign corner_ok = 64'(corner_v) < MAX_VERTICES;
    assign hit       = r_rd.valid && (r_rd.lo == r_lo) && (r_rd.hi == r_hi);

    always_comb begin
        emit_go  = 1'b0;
        fin_go   = 1'b0;
        emit_res = '0;
        case (r_state)
            S_VMAP: begin
                emit_go        = corner_ok && can_push;
                emit_res.kind  = KIND_VMAP;
                emit_res.slot  = SLOT_BITS'(corner_v);
                emit_res.value = SLOT_BITS'(r_tri);
            end
            S_LNK0: begin
                emit_go        = can_push;
                emit_res.kind  = KIND_ADJ;
                emit_res.slot  = r_base + SLOT_BITS'(eopp);
                emit_res.value = r_rd.base;
            end
            S_LNK1: begin
                emit_go        = can_push;
                emit_res.kind  = KIND_ADJ;
                emit_res.slot  = r_rd.base + SLOT_BITS'(r_rd.opp);
                emit_res.value = r_base;
            end
            S_FLAG: begin
                emit_go      = r_ovf && can_push;
                emit_res.ovf = 1'b1;
            end
            S_END: begin
                fin_go = can_push;
            end
            default: begin
                emit_go = 1'b0;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
        end else if (r_state == S_PCMP && !r_rd.valid) begin
            mem_we         = 1'b1;
            mem_wdata.valid = 1'b1;
            mem_wdata.lo   = r_lo;
            mem_wdata.hi   = r_hi;
            mem_wdata.base = r_base;
            mem_wdata.opp  = eopp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (out_load) begin
                r_out <= fin_go ? pend_last : r_pend;
            end
            if (emit_go) begin
                r_pend   <= emit_res;
                r_pend_v <= 1'b1;
            end else if (fin_go && r_pend_v) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_addr     <= '0;
            r_have     <= 1'b0;
            r_tri      <= '0;
            r_ovf      <= 1'b0;
            r_numbered <= 1'b0;
            r_c        <= '0;
            r_e        <= '0;
            r_k        <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        r_tri   <= '0;
                        r_state <= r_have ? S_START : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_item;
                        r_have <= 1'b1;
                        r_addr <= '0;
                        r_state <= i_item.first ? S_CLR : S_START;
                    end
                end
                S_START: begin
                    r_c    <= '0;
                    r_base <= SLOT_BITS'({r_tri, 1'b0}) + SLOT_BITS'(r_tri);
                    if (32'(r_tri) >= MAX_TRIANGLES) begin
                        r_ovf      <= 1'b1;
                        r_numbered <= 1'b0;
                        r_state    <= S_FLAG;
                    end else begin
                        r_ovf      <= 1'b0;
                        r_numbered <= 1'b1;
                        r_state    <= S_VMAP;
                    end
                end
                S_VMAP: begin
                    if (!corner_ok || can_push) begin
                        r_c <= r_c + 1'b1;
                        if (r_c == 2'd2) begin
                            r_e     <= '0;
                            r_state <= S_PSET;
                        end
                    end
                end
                S_PSET: begin
                    r_lo    <= (ea < eb) ? ea : eb;
                    r_hi    <= (ea < eb) ? eb : ea;
                    r_addr  <= edge_hash((ea < eb) ? ea : eb, (ea < eb) ? eb : ea);
                    r_k     <= '0;
                    r_state <= S_PRD;
                end
                S_PRD: begin
                    r_state <= S_PCMP;
                end
                S_PCMP: begin
                    if (!r_rd.valid) begin
                        r_e     <= r_e + 1'b1;
                        r_state <= (r_e == 2'd2) ? S_FLAG : S_PSET;
                    end else if (hit) begin
                        r_state <= S_LNK0;
                    end else if (r_k == LAST_ADDR) begin
                        // table full, key dropped
                        r_ovf   <= 1'b1;
                        r_e     <= r_e + 1'b1;
                        r_state <= (r_e == 2'd2) ? S_FLAG : S_PSET;
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_k     <= r_k + 1'b1;
                        r_state <= S_PRD;
                    end
                end
                S_LNK0: begin
                    if (can_push) begin
                        r_state <= S_LNK1;
                    end
                end
                S_LNK1: begin
                    if (can_push) begin
                        r_e     <= r_e + 1'b1;
                        r_state <= (r_e == 2'd2) ? S_FLAG : S_PSET;
                    end
                end
                S_FLAG: begin
                    if (!r_ovf || can_push) begin
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (can_push) begin
                        if (r_numbered) begin
                            r_tri <= r_tri + 1'b1;
                        end
                        r_have  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/triangle_edge_adjacency_builder_top.sv */
// ----------------------------------------------------------------------------
// triangle_edge_adjacency_builder_top
// builds vertex map and corner adjacency writes from a triangle stream
// ----------------------------------------------------------------------------
// input channel s_axis: one triangle per transaction, three vertex indices in
// tdata, tuser marks the first triangle of a mesh
// output channel m_axis: one write per transaction, tlast on the final write
// of a triangle; overflow results carry a zero slot and value
// config: i_cfg_we/i_cfg_wdata write the generation enable, reset value 1;
// with it low every triangle is taken and dropped
// steps per triangle: take and number it, the map writes, per edge a probe
// of the edge table, with further probe steps on collisions and, on a hit,
// the adjacency pair, then the finish
// first of mesh adds a clearing sweep over all 8192 slots of the edge table
// reset: the same sweep runs, with s_axis tready held low
// a two-entry queue keeps taking triangles while the engine works; when the
// receiver stalls, results pile up in the staging registers and the engine,
// then the queue, then s_axis tready stop
// ----------------------------------------------------------------------------
module triangle_edge_adjacency_builder_top
    import tea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // vertex_a, vertex_b, vertex_c
    input  logic        i_s_axis_tuser,  // first_of_mesh
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // write_slot, write_value, zero pad
    output logic [1:0]  o_m_axis_tuser,  // write_kind, overflow
    output logic        o_m_axis_tlast
);

    t_eng_status status;
    t_tri_item   push_item;
    t_tri_item   pop_item;
    t_result     res;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_valid;

    tea_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_first     (i_s_axis_tuser),
        .i_status    (status),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    tea_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    tea_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (pop_item),
        .o_pop     (pop),
        .o_status  (status),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (res)
    );

    assign o_m_axis_tdata = {4'd0, res.value, res.slot};
    assign o_m_axis_tuser = {res.ovf, res.kind};
    assign o_m_axis_tlast = res.last;

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.init_busy |-> !o_s_axis_tready)
        else $error("input taken during table clear");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |->
            (o_m_axis_tdata[35:0] == 36'd0) && !o_m_axis_tuser[0])
        else $error("overflow result with payload");

    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tlast)
        else $error("overflow result not final");

endmodule
